// ----- rtl/core/tli_pkg.sv -----
// Package for the table interpolation block: operation and register codes,
// select codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package tli_pkg;

  localparam int MAX_ROWS_DEF    = 256;
  localparam int MAX_COLUMNS_DEF = 8;

  // input operation codes
  localparam logic [1:0] OP_TIME  = 2'd0;
  localparam logic [1:0] OP_VALUE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_COLS = 2'd2;

  // time memory read address select
  localparam logic [2:0] TS_ZERO  = 3'd0;
  localparam logic [2:0] TS_NLAST = 3'd1;
  localparam logic [2:0] TS_SCAN  = 3'd2;
  localparam logic [2:0] TS_LEFT  = 3'd3;
  localparam logic [2:0] TS_RIGHT = 3'd4;

  // value memory row select
  localparam logic [1:0] VS_HOLD  = 2'd0;
  localparam logic [1:0] VS_LEFT  = 2'd1;
  localparam logic [1:0] VS_RIGHT = 2'd2;

  typedef struct packed {
    logic       wr;
    logic       start;
    logic       lat_t0;
    logic       lat_tn;
    logic       classify;
    logic       scan_go;
    logic       lat_tl;
    logic       lat_tr;
    logic       div_init;
    logic       div_go;
    logic       lat_yl;
    logic       mul_init;
    logic       mul_go;
    logic       out_load;
    logic       col_next;
    logic [2:0] tsel;
    logic [1:0] vsel;
  } tli_cmd_t;

  typedef struct packed {
    logic no_cols;
    logic in_span;
    logic scan_end;
    logic lin;
    logic div_end;
    logic mul_end;
    logic last_col;
  } tli_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/table_linear_interpolation.sv -----
// Top level of the breakpoint table lookup with linear or held output.
// Instantiates tli_ctrl and tli_dpath; depends on tli_pkg.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, operation,row,column,... | write or query beat in
//   out     | out_valid/out_ready, column,value,flags     | one beat per column
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data    | register write beat
//
// A write beat is stored at the edge that accepts it. A query ends after its
// first read when no columns are in use; else it reads the end times, scans
// the rows when inside the table, reads the bracketing times, divides in
// linear mode, then per column reads the values, multiplies in linear mode
// and sends the output beat, using one shared divider and shift-add multiplier.
// Reset restores mode linear, 2 rows, 1 column; memories are not cleared.
// A stalled result holds the sequencer; no new beat is taken until done.
`default_nettype none

module table_linear_interpolation
  import tli_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_row,
  input  wire logic [2:0]  in_column,
  input  wire logic [31:0] in_write_data,
  input  wire logic [31:0] in_query_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_column,
  output logic [31:0]      out_value,
  output logic             out_extrapolating,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  tli_cmd_t cmd;
  tli_sts_t sts;

  assign cfg_ready = 1'b1;

  tli_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  tli_dpath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_row            (in_row),
    .in_column         (in_column),
    .in_write_data     (in_write_data),
    .in_query_time     (in_query_time),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_column        (out_column),
    .out_value         (out_value),
    .out_extrapolating (out_extrapolating),
    .out_last          (out_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

`default_nettype wire

// ----- rtl/core/tli_ctrl.sv -----
// Sequencer for the table interpolation block: steps one beat through
// search, divide and per-column blend. Depends on tli_pkg.
`default_nettype none

module tli_ctrl
  import tli_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_operation,
  output logic            in_ready,
  input  wire logic       out_ready,
  input  wire tli_sts_t   sts,
  output tli_cmd_t        cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_T0    = 5'd1;
  localparam logic [4:0] S_TN    = 5'd2;
  localparam logic [4:0] S_CLS   = 5'd3;
  localparam logic [4:0] S_CLS2  = 5'd4;
  localparam logic [4:0] S_SCAN  = 5'd5;
  localparam logic [4:0] S_DRAIN = 5'd6;
  localparam logic [4:0] S_TL    = 5'd7;
  localparam logic [4:0] S_TR    = 5'd8;
  localparam logic [4:0] S_DCHK  = 5'd9;
  localparam logic [4:0] S_DSET  = 5'd10;
  localparam logic [4:0] S_DIV   = 5'd11;
  localparam logic [4:0] S_COLA  = 5'd12;
  localparam logic [4:0] S_COLB  = 5'd13;
  localparam logic [4:0] S_COLC  = 5'd14;
  localparam logic [4:0] S_MUL   = 5'd15;
  localparam logic [4:0] S_OUTL  = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.tsel  = TS_ZERO;
    cmd.vsel  = VS_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_operation == OP_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = S_T0;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_T0: begin
        cmd.tsel  = TS_ZERO;
        state_nxt = sts.no_cols ? S_IDLE : S_TN;
      end
      S_TN: begin
        cmd.tsel   = TS_NLAST;
        cmd.lat_t0 = 1'b1;
        state_nxt  = S_CLS;
      end
      S_CLS: begin
        cmd.lat_tn = 1'b1;
        state_nxt  = S_CLS2;
      end
      S_CLS2: begin
        cmd.classify = 1'b1;
        state_nxt    = sts.in_span ? S_SCAN : S_TL;
      end
      S_SCAN: begin
        cmd.tsel    = TS_SCAN;
        cmd.scan_go = 1'b1;
        if (sts.scan_end) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_TL;
      S_TL: begin
        cmd.tsel  = TS_LEFT;
        state_nxt = S_TR;
      end
      S_TR: begin
        cmd.tsel   = TS_RIGHT;
        cmd.lat_tl = 1'b1;
        state_nxt  = S_DCHK;
      end
      S_DCHK: begin
        cmd.lat_tr = 1'b1;
        state_nxt  = S_DSET;
      end
      S_DSET: begin
        cmd.div_init = 1'b1;
        state_nxt    = sts.lin ? S_DIV : S_COLA;
      end
      S_DIV: begin
        cmd.div_go = 1'b1;
        if (sts.div_end) state_nxt = S_COLA;
      end
      S_COLA: begin
        cmd.vsel  = sts.lin ? VS_LEFT : VS_HOLD;
        state_nxt = S_COLB;
      end
      S_COLB: begin
        cmd.lat_yl = 1'b1;
        cmd.vsel   = VS_RIGHT;
        state_nxt  = sts.lin ? S_COLC : S_OUTL;
      end
      S_COLC: begin
        cmd.mul_init = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        if (sts.mul_end) state_nxt = S_OUTL;
      end
      S_OUTL: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (sts.last_col) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.col_next = 1'b1;
            state_nxt    = S_COLA;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/tli_dpath.sv -----
// Datapath for the table interpolation block: time and value memories,
// config registers, interval scan, serial divider, serial multiplier and
// output register. Depends on tli_pkg.
`default_nettype none

module tli_dpath
  import tli_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_row,
  input  wire logic [2:0]  in_column,
  input  wire logic [31:0] in_write_data,
  input  wire logic [31:0] in_query_time,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [2:0]       out_column,
  output logic [31:0]      out_value,
  output logic             out_extrapolating,
  output logic             out_last,
  input  wire tli_cmd_t    cmd,
  output tli_sts_t         sts
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int NW = $clog2(MAX_ROWS + 1);
  localparam int VW = $clog2(MAX_ROWS * MAX_COLUMNS);
  localparam int VD = MAX_ROWS * MAX_COLUMNS;

  // configuration
  logic       mode_r;
  logic [8:0] rows_r;
  logic [3:0] cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      rows_r <= 9'd2;
      cols_r <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= cfg_data[0];
        CFG_ROWS: rows_r <= cfg_data[8:0];
        CFG_COLS: cols_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // query context
  logic signed [31:0] x_r, t0_r, tn_r, tl_r, tr_r, yl_r;
  logic [NW-1:0]      n_r;
  logic [3:0]         c_r, j_r;
  logic               qmode_r;
  logic [RW-1:0]      i_r, scan_r, pidx_r;
  logic               pend_r, below_r, above_r, extrap_r;
  logic signed [31:0] t_rd, v_rd;

  logic below, above;
  assign below = x_r < t0_r;
  assign above = x_r >= tn_r;

  // memories
  logic [31:0] tmem [MAX_ROWS];
  logic [31:0] vmem [VD];
  logic [RW-1:0] t_addr, vrow, hold_row;
  logic [VW-1:0] v_addr, w_addr;
  logic          wr_t, wr_v;

  assign wr_t   = cmd.wr && in_operation == OP_TIME && int'(in_row) < MAX_ROWS;
  assign wr_v   = cmd.wr && in_operation == OP_VALUE && int'(in_row) < MAX_ROWS
                  && int'(in_column) < MAX_COLUMNS;
  assign w_addr = VW'(in_row) * VW'(MAX_COLUMNS) + VW'(in_column);

  assign hold_row = below_r ? '0 : (above_r ? i_r : i_r - RW'(1));

  always_comb begin
    case (cmd.tsel)
      TS_NLAST: t_addr = RW'(n_r - NW'(1));
      TS_SCAN:  t_addr = scan_r;
      TS_LEFT:  t_addr = i_r - RW'(1);
      TS_RIGHT: t_addr = i_r;
      default:  t_addr = '0;
    endcase
    case (cmd.vsel)
      VS_LEFT:  vrow = i_r - RW'(1);
      VS_RIGHT: vrow = i_r;
      default:  vrow = hold_row;
    endcase
  end
  assign v_addr = VW'(vrow) * VW'(MAX_COLUMNS) + VW'(j_r);

  always_ff @(posedge clk) begin
    if (wr_t) tmem[RW'(in_row)] <= in_write_data;
    t_rd <= tmem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_v) vmem[w_addr] <= in_write_data;
    v_rd <= vmem[v_addr];
  end

  // search and context registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r     <= in_query_time;
      qmode_r <= mode_r;
      j_r     <= '0;
      if (rows_r < 9'd2)                  n_r <= NW'(2);
      else if (int'(rows_r) > MAX_ROWS)   n_r <= NW'(MAX_ROWS);
      else                                n_r <= NW'(rows_r);
      c_r <= (int'(cols_r) > MAX_COLUMNS) ? 4'(MAX_COLUMNS) : cols_r;
    end
    if (cmd.col_next) j_r  <= j_r + 4'd1;
    if (cmd.lat_t0)   t0_r <= t_rd;
    if (cmd.lat_tn)   tn_r <= t_rd;
    if (cmd.lat_tl)   tl_r <= t_rd;
    if (cmd.lat_tr)   tr_r <= t_rd;
    if (cmd.lat_yl)   yl_r <= v_rd;
    if (cmd.classify) begin
      below_r  <= below;
      above_r  <= above;
      extrap_r <= below || (x_r > tn_r);
      i_r      <= (above && !below) ? RW'(n_r - NW'(1)) : RW'(1);
      scan_r   <= '0;
    end
    if (cmd.scan_go) begin
      scan_r <= scan_r + RW'(1);
      pidx_r <= scan_r;
    end
    // compare acts in the cycle after the read; later rows overwrite
    if (pend_r && t_rd <= x_r) i_r <= pidx_r + RW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else        pend_r <= cmd.scan_go;
  end

  // serial divider: |x-tl|<<16 / |tr-tl|, one quotient bit a cycle
  logic signed [32:0] xd, dd;
  logic [32:0]        axd, add;
  logic [48:0]        num_r, q_r;
  logic [32:0]        den_r, rem_r;
  logic [5:0]         dcnt_r;
  logic               wsign_r;
  logic [33:0]        rem_sh;
  logic               ge;

  assign xd     = {x_r[31], x_r} - {tl_r[31], tl_r};
  assign dd     = {tr_r[31], tr_r} - {tl_r[31], tl_r};
  assign axd    = xd[32] ? 33'(-xd) : 33'(xd);
  assign add    = dd[32] ? 33'(-dd) : 33'(dd);
  assign rem_sh = {rem_r, num_r[48]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r   <= {axd, 16'd0};
      den_r   <= add;
      rem_r   <= '0;
      q_r     <= '0;
      dcnt_r  <= '0;
      wsign_r <= xd[32] ^ dd[32];
    end else if (cmd.div_go) begin
      num_r  <= {num_r[47:0], 1'b0};
      rem_r  <= ge ? 33'(rem_sh - {1'b0, den_r}) : 33'(rem_sh);
      q_r    <= {q_r[47:0], ge};
      dcnt_r <= dcnt_r + 6'd1;
    end
  end

  // serial multiplier: weight times |yr-yl|, MSB first, with overflow sticky
  logic signed [32:0] ydiff;
  logic [32:0]        ad_r;
  logic [51:0]        acc_r, acc_sum;
  logic               big_r, neg_r;
  logic [5:0]         mcnt_r;

  assign ydiff   = {v_rd[31], v_rd} - {yl_r[31], yl_r};
  assign acc_sum = {acc_r[50:0], 1'b0} + (ad_r[32] ? {3'd0, q_r} : 52'd0);

  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      ad_r   <= ydiff[32] ? 33'(-ydiff) : 33'(ydiff);
      neg_r  <= wsign_r ^ ydiff[32];
      acc_r  <= '0;
      big_r  <= 1'b0;
      mcnt_r <= '0;
    end else if (cmd.mul_go) begin
      ad_r   <= {ad_r[31:0], 1'b0};
      acc_r  <= acc_sum;
      big_r  <= big_r | (acc_sum[51:50] != 2'd0);
      mcnt_r <= mcnt_r + 6'd1;
    end
  end

  // floor of signed product / 65536, added to yl and saturated
  logic [50:0]        rnd;
  logic signed [35:0] term, sum;
  logic signed [31:0] blend;

  assign rnd  = {1'b0, acc_r[49:0]} + 51'h0FFFF;
  assign term = neg_r ? 36'(-$signed({1'b0, rnd[50:16]})) : {2'd0, acc_r[49:16]};
  assign sum  = {{4{yl_r[31]}}, yl_r} + term;

  always_comb begin
    if (big_r)                      blend = neg_r ? 32'sh80000000 : 32'sh7FFFFFFF;
    else if (sum > 36'sh07FFFFFFF)  blend = 32'sh7FFFFFFF;
    else if (sum < -36'sh080000000) blend = 32'sh80000000;
    else                            blend = sum[31:0];
  end

  // output register
  logic        ov_r, olast_r, oext_r;
  logic [2:0]  ocol_r;
  logic [31:0] oval_r;
  logic        lin;

  assign lin = qmode_r && (tl_r != tr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.out_load) ov_r <= 1'b1;
    else if (out_ready)    ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ocol_r  <= j_r[2:0];
      oval_r  <= lin ? blend : yl_r;
      oext_r  <= extrap_r;
      olast_r <= sts.last_col;
    end
  end

  assign out_valid         = ov_r;
  assign out_column        = ocol_r;
  assign out_value         = oval_r;
  assign out_extrapolating = oext_r;
  assign out_last          = olast_r;

  // status
  assign sts.no_cols  = (c_r == 4'd0);
  assign sts.in_span  = !below && !above;
  assign sts.scan_end = (scan_r == RW'(n_r - NW'(2)));
  assign sts.lin      = lin;
  assign sts.div_end  = (dcnt_r == 6'd48);
  assign sts.mul_end  = (mcnt_r == 6'd32);
  assign sts.last_col = (j_r == c_r - 4'd1);

endmodule

`default_nettype wire
